/* src/esbc_pkg.sv */
// Shared types, codes and port widths for the expiry sorted bounded cache.
`default_nettype none

package esbc_pkg;

  // Field widths
  localparam int unsigned NODE_W    = 64;
  localparam int unsigned SERVICE_W = 64;
  localparam int unsigned EXPIRY_W  = 64;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned STATUS_W  = 2;

  // Stream port widths
  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 208;
  localparam int unsigned OUT_USER_W = 2;

  // Item kinds
  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONSUMED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // One stored entry
  typedef struct packed {
    logic [NODE_W-1:0]    node;
    logic [SERVICE_W-1:0] service;
    logic [EXPIRY_W-1:0]  expiry;
    logic [SLOT_W-1:0]    slot;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load;          // latch accepted transaction
    logic                set_status;    // record result status
    logic [STATUS_W-1:0] status;
    logic                rd_tail;       // read last position
    logic                evict;         // drop tail from working count
    logic                add_start;     // read topmost held entry
    logic                step_down;     // read next lower entry
    logic                shift_up;      // move read entry one position up
    logic                wr_new_above;  // place new entry above read entry
    logic                wr_new0;       // place new entry at the front
    logic                con_start;     // read second entry
    logic                shift_down;    // move read entry one position down
    logic                step_up;       // read next higher entry
    logic                cnt_inc;
    logic                cnt_dec;
    logic                out_load;      // load result register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic kind_consume;
    logic full;
    logic wc_zero;
    logic wc_one;
    logic tail_later;
    logic walk_ge;
    logic ptr_zero;
    logic ptr_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/expiry_sorted_bounded_cache_core.sv */
// Transactions: consume on an empty or single-entry cache is the shortest path; add on a full
// cache that evicts the tail and walks to the front is the longest.
// Throughput: one transaction at a time; the walk moves one held entry per cycle, and a
// result waiting on out_tready holds the controller before it takes the next item.
// Reset: synchronous active-low rst_n empties the cache; RAM contents need no clearing.
`default_nettype none

module expiry_sorted_bounded_cache_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // tdata: node_id[63:0], service_id[127:64], expiry_time[191:128], slot_index[199:192]
  input  wire logic [esbc_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser: kind[0]
  input  wire logic [esbc_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // tdata: is_empty[0], entry_count[5:1], head_node[69:6], head_service[133:70],
  //        head_expiry[197:134], head_slot[205:198], zero fill[207:206]
  output logic      [esbc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser: status[1:0]
  output logic      [esbc_pkg::OUT_USER_W-1:0]      out_tuser
);

  esbc_pkg::ctl_cmd_t cmd;
  esbc_pkg::dp_stat_t stat;

  esbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  esbc_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* src/esbc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module esbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/esbc_ctrl.sv */
// Controller state machine sequencing insert and pop walks over the entry RAM.
`default_nettype none

module esbc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire esbc_pkg::dp_stat_t stat,
  output esbc_pkg::ctl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_TAIL   = 3'd2;
  localparam logic [2:0] S_AWALK  = 3'd3;
  localparam logic [2:0] S_ANEW   = 3'd4;
  localparam logic [2:0] S_CWALK  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = esbc_pkg::ST_ADDED;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.kind_consume) begin
          if (stat.wc_zero) begin
            cmd.set_status = 1'b1;
            cmd.status     = esbc_pkg::ST_EMPTY;
            state_nxt      = S_DONE;
          end else if (stat.wc_one) begin
            cmd.set_status = 1'b1;
            cmd.status     = esbc_pkg::ST_CONSUMED;
            cmd.cnt_dec    = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            cmd.con_start = 1'b1;
            state_nxt     = S_CWALK;
          end
        end else if (stat.full) begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_TAIL;
        end else if (stat.wc_zero) begin
          state_nxt = S_ANEW;
        end else begin
          cmd.add_start = 1'b1;
          state_nxt     = S_AWALK;
        end
      end
      S_TAIL: begin
        // if the tail expires later, evict it and decide again with one place free; else reject
        if (stat.tail_later) begin
          cmd.evict = 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = esbc_pkg::ST_REJECTED;
          state_nxt      = S_DONE;
        end
      end
      S_AWALK: begin
        if (stat.walk_ge) begin
          cmd.shift_up = 1'b1;
          if (stat.ptr_zero) begin
            state_nxt = S_ANEW;
          end else begin
            cmd.step_down = 1'b1;
          end
        end else begin
          cmd.wr_new_above = 1'b1;
          cmd.cnt_inc      = 1'b1;
          cmd.set_status   = 1'b1;
          cmd.status       = esbc_pkg::ST_ADDED;
          state_nxt        = S_DONE;
        end
      end
      S_ANEW: begin
        cmd.wr_new0    = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = esbc_pkg::ST_ADDED;
        state_nxt      = S_DONE;
      end
      S_CWALK: begin
        cmd.shift_down = 1'b1;
        if (stat.ptr_last) begin
          cmd.cnt_dec    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = esbc_pkg::ST_CONSUMED;
          state_nxt      = S_DONE;
        end else begin
          cmd.step_up = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/esbc_dpath.sv */
// Datapath: item latch, working count, walk pointer, head copy, entry RAM and result register.
`default_nettype none

module esbc_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire esbc_pkg::ctl_cmd_t                   cmd,
  output esbc_pkg::dp_stat_t                        stat,
  input  wire logic [esbc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic [esbc_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [esbc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic      [esbc_pkg::OUT_USER_W-1:0]      out_tuser
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(esbc_pkg::entry_t);

  esbc_pkg::entry_t item_r, head_r, rd_data, wr_data;
  logic             kind_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    wc_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             rd_en, wr_en;
  logic [esbc_pkg::STATUS_W-1:0] status_r;

  logic                           out_valid_r;
  logic [esbc_pkg::STATUS_W-1:0]  out_status_r;
  logic                           out_empty_r;
  logic [esbc_pkg::COUNT_W-1:0]   out_count_r;
  esbc_pkg::entry_t               out_head_r;

  // Item latch and working count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r         <= in_tuser[0];
      item_r.node    <= in_tdata[63:0];
      item_r.service <= in_tdata[127:64];
      item_r.expiry  <= in_tdata[191:128];
      item_r.slot    <= in_tdata[199:192];
      wc_r           <= count_r;
    end else if (cmd.evict) begin
      wc_r <= wc_r - CW'(1);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  // RAM read address and walk pointer
  always_comb begin
    priority if (cmd.rd_tail) begin
      rd_addr = AW'(CAPACITY - 1);
    end else if (cmd.add_start) begin
      rd_addr = AW'(wc_r - CW'(1));
    end else if (cmd.step_down) begin
      rd_addr = ptr_r - AW'(1);
    end else if (cmd.con_start) begin
      rd_addr = AW'(1);
    end else begin
      rd_addr = ptr_r + AW'(1);
    end
  end

  assign rd_en   = cmd.rd_tail | cmd.add_start | cmd.step_down | cmd.con_start | cmd.step_up;
  assign ptr_nxt = (cmd.add_start | cmd.step_down | cmd.con_start | cmd.step_up) ?
                   rd_addr : ptr_r;

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
  end

  // RAM write port
  assign wr_en = cmd.shift_up | cmd.wr_new_above | cmd.wr_new0 | cmd.shift_down;

  always_comb begin
    priority if (cmd.shift_up || cmd.wr_new_above) begin
      wr_addr = ptr_r + AW'(1);
    end else if (cmd.wr_new0) begin
      wr_addr = '0;
    end else begin
      wr_addr = ptr_r - AW'(1);
    end
  end

  assign wr_data = (cmd.shift_up || cmd.shift_down) ? rd_data : item_r;

  esbc_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Front entry copy
  always_ff @(posedge clk) begin
    if (cmd.wr_new0) begin
      head_r <= item_r;
    end else if (cmd.shift_down && (ptr_r == AW'(1))) begin
      head_r <= rd_data;
    end
  end

  // Held count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = wc_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = wc_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load | (out_valid_r & ~out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_empty_r  <= (count_r == '0);
      out_count_r  <= esbc_pkg::COUNT_W'(count_r);
      out_head_r   <= (count_r != '0) ? head_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_head_r.slot, out_head_r.expiry, out_head_r.service,
                       out_head_r.node, out_count_r, out_empty_r};

  // Status to controller
  always_comb begin
    stat              = '0;
    stat.kind_consume = (kind_r == esbc_pkg::KIND_CONSUME);
    stat.full         = (wc_r == CW'(CAPACITY));
    stat.wc_zero      = (wc_r == '0);
    stat.wc_one       = (wc_r == CW'(1));
    stat.tail_later   = (rd_data.expiry > item_r.expiry);
    stat.walk_ge      = (rd_data.expiry >= item_r.expiry);
    stat.ptr_zero     = (ptr_r == '0);
    stat.ptr_last     = (CW'(ptr_r) == (wc_r - CW'(1)));
    stat.out_busy     = out_valid_r & ~out_tready;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write at the same entry in one cycle");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) < CW'(CAPACITY)))
    else $error("write beyond capacity");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_head_r == '0))
    else $error("empty result carries a nonzero head");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the expiry sorted bounded cache core.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned RAND_ITEMS  = 1500;
  localparam int unsigned LIMIT_CYCLE = 400000;
  localparam int unsigned DRAIN_CYCLE = 40;

  // Expected result fields
  typedef struct packed {
    logic [esbc_pkg::STATUS_W-1:0]  status;
    logic                           is_empty;
    logic [esbc_pkg::COUNT_W-1:0]   count;
    logic [esbc_pkg::NODE_W-1:0]    node;
    logic [esbc_pkg::SERVICE_W-1:0] service;
    logic [esbc_pkg::EXPIRY_W-1:0]  expiry;
    logic [esbc_pkg::SLOT_W-1:0]    slot;
  } head_view_t;

  // One row of the directed table
  typedef struct {
    logic             kind;
    esbc_pkg::entry_t ent;
    bit               typed;
    head_view_t       want;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [esbc_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [esbc_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [esbc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [esbc_pkg::OUT_USER_W-1:0] out_tuser;

  // Predictor state: entries kept sorted, position 0 is the front
  esbc_pkg::entry_t sorted_ent[CAPACITY];
  int unsigned      sorted_cnt;

  head_view_t  pending_heads[$];
  stim_row_t   directed_rows[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left;

  expiry_sorted_bounded_cache_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLE) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_heads.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Apply one transaction to the predicted cache and return the expected head view
  function automatic head_view_t cache_apply(input logic kind, input esbc_pkg::entry_t ent);
    head_view_t  res;
    int unsigned pos;
    int          i;
    res = '0;
    if (kind == esbc_pkg::KIND_ADD) begin
      if (sorted_cnt == CAPACITY && !(sorted_ent[CAPACITY-1].expiry > ent.expiry)) begin
        res.status = esbc_pkg::ST_REJECTED;
      end else begin
        // full cache with a later tail: the tail is dropped first
        if (sorted_cnt == CAPACITY) sorted_cnt--;
        pos = 0;
        while (pos < sorted_cnt && sorted_ent[pos].expiry < ent.expiry) pos++;
        for (i = sorted_cnt; i > int'(pos); i--) sorted_ent[i] = sorted_ent[i-1];
        sorted_ent[pos] = ent;
        sorted_cnt++;
        res.status = esbc_pkg::ST_ADDED;
      end
    end else if (sorted_cnt == 0) begin
      res.status = esbc_pkg::ST_EMPTY;
    end else begin
      for (i = 1; i < int'(sorted_cnt); i++) sorted_ent[i-1] = sorted_ent[i];
      sorted_cnt--;
      res.status = esbc_pkg::ST_CONSUMED;
    end
    res.is_empty = (sorted_cnt == 0);
    res.count    = sorted_cnt[esbc_pkg::COUNT_W-1:0];
    if (sorted_cnt != 0) begin
      res.node    = sorted_ent[0].node;
      res.service = sorted_ent[0].service;
      res.expiry  = sorted_ent[0].expiry;
      res.slot    = sorted_ent[0].slot;
    end
    return res;
  endfunction

  // Random 64-bit field value leaning on extremes
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 15));
      3:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random expiry: mostly a narrow range so that ties and evictions happen often
  function automatic logic [63:0] rand_expiry();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 64'($urandom_range(0, 31));
      5:             return '0;
      6:             return '1;
      7:             return ~64'($urandom_range(0, 31));
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_row(input logic kind, input logic [63:0] node, input logic [63:0] service,
                          input logic [63:0] expiry, input logic [7:0] slot, input bit typed,
                          input head_view_t want);
    stim_row_t row;
    row.kind        = kind;
    row.ent.node    = node;
    row.ent.service = service;
    row.ent.expiry  = expiry;
    row.ent.slot    = slot;
    row.typed       = typed;
    row.want        = want;
    directed_rows.push_back(row);
  endtask

  // Send one transaction, record its expectation, then idle between bursts
  task automatic send_item(input logic kind, input esbc_pkg::entry_t ent, input bit typed,
                           input head_view_t want);
    head_view_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ent.slot, ent.expiry, ent.service, ent.node};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = cache_apply(kind, ent);
    pending_heads.push_back(typed ? want : predicted);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // long bursts now and then give stretches without gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // Result checker
  task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    head_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_heads.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tuser %h tdata %h",
                 $time, out_tuser, out_tdata);
        err_cnt++;
      end else begin
        want = pending_heads.pop_front();
        check_field("status",       64'(want.status),   64'(out_tuser[1:0]));
        check_field("is_empty",     64'(want.is_empty), 64'(out_tdata[0]));
        check_field("entry_count",  64'(want.count),    64'(out_tdata[5:1]));
        check_field("head_node",    want.node,          out_tdata[69:6]);
        check_field("head_service", want.service,       out_tdata[133:70]);
        check_field("head_expiry",  want.expiry,        out_tdata[197:134]);
        check_field("head_slot",    64'(want.slot),     64'(out_tdata[205:198]));
      end
    end
  end

  // Receiver: back-pressure in modes that change from span to span
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (k = 0; k < span; k++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= k[0];
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    esbc_pkg::entry_t ent;
    logic             kind;
    int unsigned      sent;
    int unsigned      seg_len;
    int unsigned      add_pct;
    int unsigned      k;
    bit               held_off;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    sorted_cnt = 0;
    burst_left = $urandom_range(1, 12);
    held_off   = 1'b0;
    for (k = 0; k < CAPACITY; k++) sorted_ent[k] = '0;

    // Directed table: consume on empty, extremes, node zero, ties, full cache cases
    push_row(esbc_pkg::KIND_CONSUME, '0, '0, '0, '0, 1,
             '{esbc_pkg::ST_EMPTY, 1'b1, 5'd0, '0, '0, '0, '0});
    push_row(esbc_pkg::KIND_ADD, '1, '1, '1, '1, 1,
             '{esbc_pkg::ST_ADDED, 1'b0, 5'd1, '1, '1, '1, '1});
    push_row(esbc_pkg::KIND_CONSUME, '1, '1, '1, '1, 1,
             '{esbc_pkg::ST_CONSUMED, 1'b1, 5'd0, '0, '0, '0, '0});
    push_row(esbc_pkg::KIND_CONSUME, '1, '0, '1, '0, 1,
             '{esbc_pkg::ST_EMPTY, 1'b1, 5'd0, '0, '0, '0, '0});
    push_row(esbc_pkg::KIND_ADD, '0, '0, '0, '0, 1,
             '{esbc_pkg::ST_ADDED, 1'b0, 5'd1, '0, '0, '0, '0});
    // equal expiry: the newer entry goes in front
    push_row(esbc_pkg::KIND_ADD, 64'd5, 64'd6, '0, 8'd7, 1,
             '{esbc_pkg::ST_ADDED, 1'b0, 5'd2, 64'd5, 64'd6, '0, 8'd7});
    // fill up to capacity, the last fill being the latest possible expiry
    for (k = 0; k < 14; k++)
      push_row(esbc_pkg::KIND_ADD, 64'h100 + 64'(k), ~(64'h100 + 64'(k)),
               (k == 13) ? '1 : 64'((k * 37) % 23 + 1), 8'(k * 17), 0, '0);
    // full, tail not later than the new entry: rejected
    push_row(esbc_pkg::KIND_ADD, 64'hAA, 64'hBB, '1, 8'h11, 1,
             '{esbc_pkg::ST_REJECTED, 1'b0, 5'd16, 64'd5, 64'd6, '0, 8'd7});
    // full, tail later: tail evicted
    push_row(esbc_pkg::KIND_ADD, 64'hCC, 64'hDD, ~64'd1, 8'h22, 1,
             '{esbc_pkg::ST_ADDED, 1'b0, 5'd16, 64'd5, 64'd6, '0, 8'd7});
    push_row(esbc_pkg::KIND_ADD, 64'hEE, 64'hFF, '1, 8'h33, 1,
             '{esbc_pkg::ST_REJECTED, 1'b0, 5'd16, 64'd5, 64'd6, '0, 8'd7});
    push_row(esbc_pkg::KIND_ADD, 64'd9, 64'd10, '0, 8'd11, 1,
             '{esbc_pkg::ST_ADDED, 1'b0, 5'd16, 64'd9, 64'd10, '0, 8'd11});
    push_row(esbc_pkg::KIND_CONSUME, '0, '0, '0, '0, 0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].kind, directed_rows[r].ent, directed_rows[r].typed,
                directed_rows[r].want);

    // Random part: segments that lean toward filling or toward draining the cache
    sent = 0;
    while (sent < RAND_ITEMS) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       add_pct = 85;
        1:       add_pct = 50;
        default: add_pct = 20;
      endcase
      for (k = 0; k < seg_len; k++) begin
        kind        = ($urandom_range(0, 99) < add_pct) ? esbc_pkg::KIND_ADD :
                                                           esbc_pkg::KIND_CONSUME;
        ent.node    = rand_word();
        ent.service = rand_word();
        ent.expiry  = rand_expiry();
        ent.slot    = 8'($urandom_range(0, 255));
        send_item(kind, ent, 0, '0);
        sent++;
        // hold off once until every result is back
        if (!held_off && sent >= RAND_ITEMS / 2) begin
          held_off = 1'b1;
          in_tvalid <= 1'b0;
          while (pending_heads.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLE) @(posedge clk);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
